>>> src/ers_pkg.sv
// shared types and constants for the event rate running statistics block
`timescale 1ns / 1ps
`default_nettype none
package ers_pkg;

   localparam logic [19:0] RATE_SCALE  = 20'd1000000;
   localparam logic [47:0] MEAN_MAX    = 48'h7FFF_FFFF_FFFF;
   localparam logic [62:0] M2_MAX      = 63'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [31:0] SAMPLES_MAX = 32'hFFFF_FFFF;
   localparam logic [4:0]  EVENTS_RESET = 5'd16;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_TIME    = 2'd1;
   localparam logic [1:0] ST_UNREG   = 2'd2;

   typedef struct packed {
      logic [3:0]  event_index;
      logic [47:0] sample_count;
      logic [62:0] time_enabled_ns;
   } ers_req_type;

   typedef struct packed {
      logic [3:0]         event_slot;
      logic [1:0]         status;
      logic [31:0]        samples_seen;
      logic signed [47:0] mean_rate;
      logic [62:0]        sum_sq_dev;
   } ers_rsp_type;

   typedef struct packed {
      logic [47:0]        last_count;
      logic [62:0]        last_time;
      logic [31:0]        sample_total;
      logic signed [47:0] mean;
      logic [62:0]        m2;
   } ers_entry_type;

endpackage
`default_nettype wire

>>> src/ers_divider.sv
// restoring divider, two quotient bits per cycle, quotient saturated to 47 bits
`timescale 1ns / 1ps
`default_nettype none
module ers_divider #(
   parameter int DIV_W = 84
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [62:0]      divisor,
   input  logic [6:0]       steps,
   output logic             done,
   output logic [47:0]      quotient
);
   import ers_pkg::*;

   logic [DIV_W-1:0] num_ff, num_in;
   logic [62:0]      rem_ff, rem_in;
   logic [62:0]      den_ff;
   logic [47:0]      q_ff, q_in;
   logic             sat_ff, sat_in;
   logic [6:0]       cnt_ff;
   logic             run_ff;
   logic             done_ff;

   logic [63:0] r1, r1s, r2, r2s;
   logic        ge1, ge2;
   logic [47:0] q1;

   always_comb begin
      r1     = {rem_ff, num_ff[DIV_W-1]};
      ge1    = r1 >= {1'b0, den_ff};
      r1s    = ge1 ? r1 - {1'b0, den_ff} : r1;
      q1     = {q_ff[46:0], ge1};
      r2     = {r1s[62:0], num_ff[DIV_W-2]};
      ge2    = r2 >= {1'b0, den_ff};
      r2s    = ge2 ? r2 - {1'b0, den_ff} : r2;
      q_in   = {q1[46:0], ge2};
      rem_in = r2s[62:0];
      sat_in = sat_ff | q1[47] | q_in[47];
      num_in = num_ff << 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && (cnt_ff == 7'd1);
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= steps;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
         q_ff   <= '0;
         sat_ff <= 1'b0;
      end else if (run_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         q_ff   <= q_in;
         sat_ff <= sat_in;
      end
   end

   assign done     = done_ff;
   assign quotient = sat_ff ? MEAN_MAX : q_ff;

endmodule
`default_nettype wire

>>> src/ers_mul.sv
// 49 by 49 bit multiplier from four 25 by 25 partial products, accumulated in turn
`timescale 1ns / 1ps
`default_nettype none
module ers_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [48:0] a,
   input  logic [48:0] b,
   output logic        done,
   output logic [97:0] prod
);
   import ers_pkg::*;

   logic [48:0] a_ff, b_ff;
   logic [97:0] acc_ff, acc_in;
   logic [1:0]  step_ff;
   logic        run_ff;
   logic        done_ff;
   logic [24:0] am, bm;
   logic [49:0] pp;
   logic [5:0]  sh;

   always_comb begin
      am     = step_ff[1] ? {1'b0, a_ff[48:25]} : a_ff[24:0];
      bm     = step_ff[0] ? {1'b0, b_ff[48:25]} : b_ff[24:0];
      pp     = am * bm;
      sh     = (step_ff[1] ? 6'd25 : 6'd0) + (step_ff[0] ? 6'd25 : 6'd0);
      acc_in = acc_ff + (98'(pp) << sh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= run_ff && (step_ff == 2'd3);
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (run_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule
`default_nettype wire

>>> src/event_rate_running_stats.sv
// top level: per-event rate statistics table with running mean and M2 update
// A word for a registered slot whose time advances and which already holds a sample passes through
// the rate division (DIV_W/2 = 42 steps at FRAC_BITS = 16 on the shared two-bit-per-cycle divider),
// the mean-step division on the same divider, the deviation product and the sequencing states. A
// first sample skips the mean step and the deviation product, and a word whose time does not advance
// skips all of them and goes straight to write-back. For a registered slot, busy is high from
// acceptance until the result strobe, and a word for an unregistered slot answers on the next cycle
// without touching the table or raising busy. rsp_valid is high for one cycle per result and the
// receiver must take it then. The slot table has a valid bit per entry, so reset is immediate with
// no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module event_rate_running_stats #(
   parameter int EVENT_SLOTS = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ers_pkg::ers_req_type req_data,
   output logic                 rsp_valid,
   output ers_pkg::ers_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [4:0]           csr_data
);
   import ers_pkg::*;

   localparam int AW    = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
   localparam int DIV_W = 68 + FRAC_BITS + (FRAC_BITS % 2);
   localparam logic [6:0] STEPS_A = 7'(DIV_W / 2);
   localparam logic [6:0] STEPS_B = 7'd25;
   localparam logic [8:0] SLOTS9  = 9'(EVENT_SLOTS);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD    = 4'd1;
   localparam logic [3:0] S_PROD  = 4'd2;
   localparam logic [3:0] S_LOADA = 4'd3;
   localparam logic [3:0] S_WAITA = 4'd4;
   localparam logic [3:0] S_DIFF  = 4'd5;
   localparam logic [3:0] S_LOADB = 4'd6;
   localparam logic [3:0] S_WAITB = 4'd7;
   localparam logic [3:0] S_NM    = 4'd8;
   localparam logic [3:0] S_MULW  = 4'd9;
   localparam logic [3:0] S_WB    = 4'd10;

   ers_entry_type mem [EVENT_SLOTS];
   logic [EVENT_SLOTS-1:0] valid_ff;

   logic [3:0]    state_ff;
   logic [4:0]    events_ff;
   ers_req_type   req_ff;
   logic [AW-1:0] idx_ff;
   ers_entry_type rd_ff, cur;
   logic          rd_valid_ff;
   logic [47:0]   dcount_ff;
   logic [62:0]   dtime_ff;
   logic [31:0]   n_ff, n_in;
   logic [67:0]   prod_ff;
   logic [47:0]   rate_ff;
   logic [48:0]   diff_ff;
   logic signed [47:0] new_mean_ff;
   logic [62:0]   new_m2_ff;
   logic [1:0]    status_ff;
   logic          rsp_valid_ff;
   ers_rsp_type   rsp_ff;

   logic          accept, unreg, time_ok;
   logic [8:0]    limit;
   logic [AW+3:0] rd_ext;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   ers_entry_type wr_data;

   logic             div_start, div_done;
   logic [DIV_W-1:0] div_a, div_b, div_num;
   logic [62:0]      div_den;
   logic [6:0]       div_steps;
   logic [47:0]      div_q;
   logic [48:0]      dmag, qs, nm49, d2, d2mag;
   logic             mul_start, mul_done;
   logic [97:0]      mul_prod, m2sh;
   logic [62:0]      inc;
   logic [63:0]      m2sum;

   assign busy      = state_ff != S_IDLE;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign limit     = ({4'b0, events_ff} < SLOTS9) ? {4'b0, events_ff} : SLOTS9;
   assign unreg     = {5'b0, req_data.event_index} >= limit;
   assign rd_ext    = {{AW{1'b0}}, req_data.event_index};
   assign rd_addr   = rd_ext[AW-1:0];
   assign cur       = rd_valid_ff ? rd_ff : '0;
   assign time_ok   = req_ff.time_enabled_ns > cur.last_time;
   assign n_in      = (cur.sample_total == SAMPLES_MAX) ? SAMPLES_MAX
                                                         : cur.sample_total + 32'd1;

   assign div_a     = DIV_W'({prod_ff, {FRAC_BITS{1'b0}}});
   assign dmag      = diff_ff[48] ? 49'(-diff_ff) : diff_ff;
   assign div_b     = {1'b0, dmag, {(DIV_W - 50){1'b0}}};
   assign div_start = (state_ff == S_LOADA) || (state_ff == S_LOADB);
   assign div_num   = (state_ff == S_LOADA) ? div_a : div_b;
   assign div_den   = (state_ff == S_LOADA) ? dtime_ff : {31'b0, n_ff};
   assign div_steps = (state_ff == S_LOADA) ? STEPS_A : STEPS_B;

   assign qs    = diff_ff[48] ? 49'(-{1'b0, div_q}) : {1'b0, div_q};
   assign nm49  = {cur.mean[47], cur.mean} + qs;
   assign d2    = {1'b0, rate_ff} - {new_mean_ff[47], new_mean_ff};
   assign d2mag = d2[48] ? 49'(-d2) : d2;
   assign mul_start = state_ff == S_NM;

   assign m2sh  = mul_prod >> FRAC_BITS;
   assign inc   = (|m2sh[97:63]) ? M2_MAX : m2sh[62:0];
   assign m2sum = {1'b0, cur.m2} + {1'b0, inc};

   ers_divider #(.DIV_W(DIV_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(div_den), .steps(div_steps), .done(div_done), .quotient(div_q)
   );

   ers_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(dmag), .b(d2mag),
      .done(mul_done), .prod(mul_prod)
   );

   assign wr_en   = state_ff == S_WB;
   assign wr_data = '{last_count: req_ff.sample_count, last_time: req_ff.time_enabled_ns,
                      sample_total: n_ff, mean: new_mean_ff, m2: new_m2_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff] <= wr_data;
      end
      if (accept) begin
         rd_ff       <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         state_ff     <= S_IDLE;
         events_ff    <= EVENTS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_WB) || (accept && unreg);
         if (csr_valid && csr_ready) begin
            events_ff <= csr_data;
         end
         if (wr_en) begin
            valid_ff[idx_ff] <= 1'b1;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept && !unreg) begin
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               state_ff <= time_ok ? S_PROD : S_WB;
            end
            S_PROD:  state_ff <= S_LOADA;
            S_LOADA: state_ff <= S_WAITA;
            S_WAITA: begin
               if (div_done) begin
                  state_ff <= (n_ff == 32'd1) ? S_WB : S_DIFF;
               end
            end
            S_DIFF:  state_ff <= S_LOADB;
            S_LOADB: state_ff <= S_WAITB;
            S_WAITB: begin
               if (div_done) begin
                  state_ff <= S_NM;
               end
            end
            S_NM:    state_ff <= S_MULW;
            S_MULW: begin
               if (mul_done) begin
                  state_ff <= S_WB;
               end
            end
            S_WB: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_ff <= req_data;
               idx_ff <= rd_addr;
               rsp_ff <= '{event_slot: req_data.event_index, status: ST_UNREG,
                           samples_seen: '0, mean_rate: '0, sum_sq_dev: '0};
            end
         end
         S_RD: begin
            dcount_ff   <= req_ff.sample_count - cur.last_count;
            dtime_ff    <= req_ff.time_enabled_ns - cur.last_time;
            n_ff        <= n_in;
            status_ff   <= time_ok ? ST_OK : ST_TIME;
            new_mean_ff <= cur.mean;
            new_m2_ff   <= cur.m2;
         end
         S_PROD: begin
            prod_ff <= dcount_ff * RATE_SCALE;
         end
         S_WAITA: begin
            if (div_done) begin
               rate_ff     <= div_q;
               new_mean_ff <= div_q;
               new_m2_ff   <= '0;
            end
         end
         S_DIFF: begin
            diff_ff <= {1'b0, rate_ff} - {cur.mean[47], cur.mean};
         end
         S_WAITB: begin
            if (div_done) begin
               new_mean_ff <= nm49[47:0];
            end
         end
         S_MULW: begin
            if (mul_done) begin
               new_m2_ff <= m2sum[63] ? M2_MAX : m2sum[62:0];
            end
         end
         S_WB: begin
            rsp_ff <= '{event_slot: req_ff.event_index, status: status_ff,
                        samples_seen: n_ff, mean_rate: new_mean_ff, sum_sq_dev: new_m2_ff};
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_wb_answers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB) |=> (rsp_valid && rsp_data.status != ST_UNREG))
      else $error("write back gave no result");

   a_unreg_fast: assert property (@(posedge clock) disable iff (reset)
      (accept && unreg) |=> (rsp_valid && rsp_data.status == ST_UNREG))
      else $error("unregistered word not answered at once");

   a_samples_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_UNREG) |-> (rsp_data.samples_seen != 32'd0))
      else $error("registered result with no samples");

endmodule
`default_nettype wire

>>> tb/event_rate_running_stats_test.sv
// testbench for the event rate running statistics block with a local model
`timescale 1ns / 1ps
`default_nettype none
module event_rate_running_stats_test;
   import ers_pkg::*;

   localparam int SLOTS = 16;
   localparam int FRAC = 16;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   ers_req_type req_data = '0;
   logic rsp_valid;
   ers_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [4:0] csr_data = '0;

   event_rate_running_stats i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // local model state
   logic [4:0] slots_registered;
   logic [47:0] prev_count [SLOTS];
   logic [62:0] prev_time [SLOTS];
   logic [31:0] sample_tally [SLOTS];
   logic signed [47:0] rate_mean [SLOTS];
   logic [62:0] rate_m2 [SLOTS];

   ers_req_type pending_words[$];
   ers_rsp_type expected_rsp[$];
   int errors = 0;
   int idle_cycles = 0;
   int words_sent = 0;

   function automatic logic [62:0] absval(logic signed [63:0] x);
      return x < 0 ? 63'(-x) : 63'(x);
   endfunction

   function automatic ers_rsp_type update_stats(ers_req_type w);
      ers_rsp_type r;
      int unsigned s;
      logic [47:0] dcount;
      logic [62:0] dtime;
      logic [127:0] num;
      logic [127:0] quot;
      logic signed [63:0] rate, old_m, diff, new_m, diff2;
      logic [125:0] prod;
      logic [125:0] inc_w;
      logic [63:0] sum;
      logic [62:0] inc;
      s = 32'(w.event_index);
      r = '0;
      r.event_slot = w.event_index;
      if (w.event_index >= ((slots_registered < SLOTS) ? slots_registered : SLOTS)) begin
         r.status = ST_UNREG;
         return r;
      end
      dcount = w.sample_count - prev_count[s];
      r.status = ST_OK;
      if (w.time_enabled_ns <= prev_time[s]) r.status = ST_TIME;
      dtime = w.time_enabled_ns - prev_time[s];
      if (sample_tally[s] != SAMPLES_MAX) sample_tally[s] = sample_tally[s] + 1;
      prev_count[s] = w.sample_count;
      prev_time[s] = w.time_enabled_ns;
      if (r.status == ST_OK) begin
         num = (128'(dcount) * 128'(RATE_SCALE)) << FRAC;
         quot = num / 128'(dtime);
         rate = (quot > 128'(MEAN_MAX)) ? 64'(MEAN_MAX) : 64'(quot);
         if (sample_tally[s] == 1) begin
            rate_mean[s] = rate[47:0];
            rate_m2[s] = '0;
         end else begin
            old_m = 64'(rate_mean[s]);
            diff = rate - old_m;
            new_m = old_m + diff / $signed({32'd0, sample_tally[s]});
            diff2 = rate - new_m;
            prod = 126'(absval(diff)) * 126'(absval(diff2));
            inc_w = prod >> FRAC;
            inc = (inc_w > 126'(M2_MAX)) ? M2_MAX : inc_w[62:0];
            sum = 64'(rate_m2[s]) + 64'(inc);
            rate_m2[s] = (sum > 64'(M2_MAX)) ? M2_MAX : sum[62:0];
            rate_mean[s] = new_m[47:0];
         end
      end
      r.samples_seen = sample_tally[s];
      r.mean_rate = rate_mean[s];
      r.sum_sq_dev = rate_m2[s];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 4);
      return $urandom_range(5, 120);
   endfunction

   logic word_taken = 1'b0;

   // driver
   int gap_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!start || word_taken) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_data <= pending_words.pop_front();
               start <= 1'b1;
               gap_left <= pick_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      word_taken = 1'b0;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (start && !busy) begin
            expected_rsp.push_back(update_stats(req_data));
            words_sent++;
            word_taken = 1'b1;
         end
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected word", 64'(rsp_data.event_slot), 0);
            end else begin
               ers_rsp_type e;
               e = expected_rsp.pop_front();
               if (rsp_data.event_slot !== e.event_slot)
                  report_mismatch("event_slot", 64'(rsp_data.event_slot), 64'(e.event_slot));
               if (rsp_data.status !== e.status)
                  report_mismatch("status", 64'(rsp_data.status), 64'(e.status));
               if (rsp_data.samples_seen !== e.samples_seen)
                  report_mismatch("samples_seen", 64'(rsp_data.samples_seen),
                     64'(e.samples_seen));
               if (rsp_data.mean_rate !== e.mean_rate)
                  report_mismatch("mean_rate", 64'(rsp_data.mean_rate), 64'(e.mean_rate));
               if (rsp_data.sum_sq_dev !== e.sum_sq_dev)
                  report_mismatch("sum_sq_dev", 64'(rsp_data.sum_sq_dev), 64'(e.sum_sq_dev));
            end
         end
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // per-slot stream generator state
   logic [47:0] gen_count [SLOTS];
   logic [62:0] gen_time [SLOTS];

   function automatic ers_req_type make_word(int kind);
      ers_req_type w;
      int s;
      s = $urandom_range(0, SLOTS - 1);
      w.event_index = 4'(s);
      if (kind < 75) begin
         // well-formed: increasing time, moderate count growth
         gen_count[s] = gen_count[s] + 48'($urandom_range(0, 100000));
         gen_time[s] = gen_time[s] + 63'($urandom_range(1, 2000000));
      end else if (kind < 85) begin
         gen_count[s] = 48'({$urandom, $urandom});
         gen_time[s] = 63'({$urandom, $urandom});
      end else if (kind < 92) begin
         gen_time[s] = gen_time[s] - 63'($urandom_range(0, 1000));
         gen_count[s] = gen_count[s] - 48'($urandom_range(0, 1000));
      end else begin
         gen_count[s] = gen_count[s] + 48'({$urandom, $urandom});
         gen_time[s] = gen_time[s] + 63'($urandom_range(1, 3));
      end
      w.sample_count = gen_count[s];
      w.time_enabled_ns = gen_time[s];
      return w;
   endfunction

   task automatic write_csr(logic [4:0] v);
      @(negedge clock);
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      slots_registered = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      wait (pending_words.size() == 0);
      while (expected_rsp.size() != 0 || start || busy) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic queue_item(logic [3:0] s, logic [47:0] c, logic [62:0] t);
      ers_req_type w;
      w.event_index = s;
      w.sample_count = c;
      w.time_enabled_ns = t;
      pending_words.push_back(w);
   endtask

   int phase_settings [5] = '{16, 1, 31, 7, 0};

   initial begin
      slots_registered = EVENTS_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         prev_count[i] = '0; prev_time[i] = '0; sample_tally[i] = '0;
         rate_mean[i] = '0; rate_m2[i] = '0;
         gen_count[i] = '0; gen_time[i] = '0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed words at reset settings
      queue_item(4'd0, 48'd100, 63'd1000);
      queue_item(4'd0, 48'd300, 63'd2000);
      queue_item(4'd0, 48'd300, 63'd2000);
      queue_item(4'd0, 48'd50, 63'd3000);
      queue_item(4'd0, 48'hFFFF_FFFF_FFFF, 63'd3001);
      queue_item(4'd0, 48'd0, 63'd3002);
      queue_item(4'd15, 48'hFFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
      queue_item(4'd15, 48'd0, 63'd5);
      queue_item(4'd1, 48'hFFFF_FFFF_FFFF, 63'd1);
      queue_item(4'd1, 48'd0, 63'h7FFF_FFFF_FFFF_FFFF);
      queue_item(4'd2, 48'd0, 63'd0);
      queue_item(4'd2, 48'd10, 63'd10);
      queue_item(4'd2, 48'd1000000, 63'd11);
      queue_item(4'd2, 48'd1000001, 63'd1_000_000_011);
      drain();
      for (int ph = 0; ph < 5; ph++) begin
         write_csr(5'(phase_settings[ph]));
         queue_item(4'd15, 48'd1, 63'd1);
         queue_item(4'd0, 48'd1, 63'd1);
         for (int k = 0; k < 345; k++) pending_words.push_back(make_word($urandom_range(0, 99)));
         drain();
      end
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> filelist.f
src/ers_pkg.sv
src/ers_divider.sv
src/ers_mul.sv
src/event_rate_running_stats.sv
tb/event_rate_running_stats_test.sv
